// ===== hdl/tds_pkg.sv =====
package tds_pkg;

	localparam int NUM_TASKS = 16;
	localparam int ID_W      = $clog2(NUM_TASKS);
	localparam int CNT_W     = $clog2(NUM_TASKS + 1);

	// commands
	localparam logic [2:0] CMD_ATTACH   = 3'd0;
	localparam logic [2:0] CMD_DEPEND   = 3'd1;
	localparam logic [2:0] CMD_START    = 3'd2;
	localparam logic [2:0] CMD_FORCE    = 3'd3;
	localparam logic [2:0] CMD_COMPLETE = 3'd4;

	// event kinds
	localparam logic [2:0] EV_WAIT   = 3'd0;
	localparam logic [2:0] EV_EXEC   = 3'd1;
	localparam logic [2:0] EV_DISP   = 3'd2;
	localparam logic [2:0] EV_DONE   = 3'd3;
	localparam logic [2:0] EV_FULL   = 3'd4;
	localparam logic [2:0] EV_REJECT = 3'd5;

	// per-task states
	localparam logic [2:0] ST_READY     = 3'd0;
	localparam logic [2:0] ST_WAITING   = 3'd1;
	localparam logic [2:0] ST_FORCED    = 3'd2;
	localparam logic [2:0] ST_EXECUTING = 3'd3;
	localparam logic [2:0] ST_COMPLETE  = 3'd4;
	localparam logic [2:0] ST_FREE      = 3'd5;

	// step flag bit positions
	localparam int FL_WAIT = 0;
	localparam int FL_EXEC = 1;
	localparam int FL_DISP = 2;

endpackage

// ===== hdl/task_dependency_scoreboard.sv =====
// Task dependency scoreboard. Holds up to NUM_TASKS tasks and the matrix of
// which task waits on which. A command word is taken when start is high and
// busy is low; busy then stays high until the cycle in which the command's
// closing word is on the event ports, and drops in that cycle. Event words
// leave one per cycle at most, each valid for exactly one cycle while
// event_strobe is high; the receiver cannot stall them, so it must sink every
// strobed word. Every command ends with one word with last set (done, table
// full or rejected). A single sequencer reads one row of the state tables
// per cycle: complete examines one dependent per cycle, and force walks
// predecessors depth first through a path stack, trying one predecessor bit
// per cycle for each task it visits. Dependency matrix rows and step flags
// of an id are only valid once the id has been attached.
module task_dependency_scoreboard (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic [2:0] command,
	input  logic [3:0] target_id,
	input  logic [3:0] before_id,
	input  logic       has_waiting_step,
	input  logic       has_execute_step,
	input  logic       has_dispose_step,
	output logic       event_strobe,
	output logic [2:0] event_kind,
	output logic [3:0] event_task,
	output logic       last
);
	import tds_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE, S_DECODE, S_DEP2, S_START2, S_FVISIT, S_FVISIT2,
		S_FSCAN, S_REL, S_DISP, S_DONE
	} fsm_t;

	fsm_t fsm_q;

	// latched command word
	logic [2:0]  cmd_q;
	logic [3:0]  tgt_q;
	logic [3:0]  bef_q;
	logic [2:0]  fl_in_q;

	// task tables
	logic [2:0]           state_q [NUM_TASKS];
	logic [NUM_TASKS-1:0] free_q;
	logic [NUM_TASKS-1:0] waits_q [NUM_TASKS];
	logic [NUM_TASKS-1:0] blocks_q [NUM_TASKS];
	logic [2:0]           flags_q [NUM_TASKS];

	// force path stack: id and next predecessor bit to try
	logic [ID_W-1:0]  stk_id_q [NUM_TASKS];
	logic [CNT_W-1:0] stk_b_q  [NUM_TASKS];
	logic [CNT_W-1:0] sp_q;
	logic [ID_W-1:0]  visit_q;

	// complete scan
	logic [NUM_TASKS-1:0] scan_q;
	logic [ID_W-1:0]      rel_b_q;

	// event output register
	logic       ev_stb_q;
	logic [2:0] ev_kind_q;
	logic [3:0] ev_task_q;
	logic       ev_last_q;

	// single read port over the tables
	logic [ID_W-1:0]      rd_idx;
	logic [2:0]           rd_state;
	logic [NUM_TASKS-1:0] rd_wmap;
	logic [2:0]           rd_flags;
	logic [ID_W-1:0]      top;
	logic [CNT_W-1:0]     top_b;
	logic [ID_W-1:0]      tgt_i;
	logic [ID_W-1:0]      bef_i;
	logic                 tgt_bad;
	logic                 bef_bad;
	logic [ID_W-1:0]      free_id;
	logic [NUM_TASKS-1:0] rel_new;

	assign tgt_i   = tgt_q[ID_W-1:0];
	assign bef_i   = bef_q[ID_W-1:0];
	assign tgt_bad = (CNT_W'(tgt_q) >= CNT_W'(NUM_TASKS));
	assign bef_bad = (CNT_W'(bef_q) >= CNT_W'(NUM_TASKS));
	assign top     = ID_W'(sp_q - CNT_W'(1));
	assign top_b   = stk_b_q[top];

	always_comb begin
		unique case (fsm_q)
			S_DEP2: begin
				rd_idx = bef_i;
			end
			S_FVISIT, S_FVISIT2: begin
				rd_idx = visit_q;
			end
			S_FSCAN: begin
				rd_idx = stk_id_q[top];
			end
			S_REL: begin
				rd_idx = rel_b_q;
			end
			default: begin
				rd_idx = tgt_i;
			end
		endcase
	end

	assign rd_state = state_q[rd_idx];
	assign rd_wmap  = waits_q[rd_idx];
	assign rd_flags = flags_q[rd_idx];
	assign rel_new  = rd_wmap & ~(NUM_TASKS'(1) << tgt_i);

	// lowest free id
	always_comb begin
		free_id = '0;
		for (int i = NUM_TASKS - 1; i >= 0; i--) begin
			if (free_q[i]) begin
				free_id = ID_W'(i);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fsm_q    <= S_IDLE;
			free_q   <= '1;
			sp_q     <= '0;
			ev_stb_q <= 1'b0;
			for (int i = 0; i < NUM_TASKS; i++) begin
				state_q[i] <= ST_FREE;
			end
		end else begin
			ev_stb_q <= 1'b0;
			unique case (fsm_q)
				S_IDLE: begin
					if (start) begin
						cmd_q   <= command;
						tgt_q   <= target_id;
						bef_q   <= before_id;
						fl_in_q <= {has_dispose_step, has_execute_step, has_waiting_step};
						fsm_q   <= S_DECODE;
					end
				end
				S_DECODE: begin
					ev_stb_q  <= 1'b1;
					ev_last_q <= 1'b1;
					ev_task_q <= tgt_q;
					fsm_q     <= S_IDLE;
					if (cmd_q == CMD_ATTACH) begin
						if (free_q == '0) begin
							ev_kind_q <= EV_FULL;
							ev_task_q <= '0;
						end else begin
							free_q[free_id]   <= 1'b0;
							state_q[free_id]  <= ST_READY;
							waits_q[free_id]  <= '0;
							blocks_q[free_id] <= '0;
							flags_q[free_id]  <= fl_in_q;
							ev_kind_q         <= EV_DONE;
							ev_task_q         <= 4'(free_id);
						end
					end else if (cmd_q > CMD_COMPLETE || tgt_bad) begin
						ev_kind_q <= EV_REJECT;
					end else begin
						unique case (cmd_q)
							CMD_DEPEND: begin
								if (bef_bad || bef_q == tgt_q || rd_state != ST_READY) begin
									ev_kind_q <= EV_REJECT;
								end else begin
									ev_stb_q <= 1'b0;
									fsm_q    <= S_DEP2;
								end
							end
							CMD_START: begin
								ev_stb_q <= 1'b0;
								if (rd_state == ST_READY) begin
									state_q[tgt_i] <= ST_WAITING;
									ev_stb_q       <= rd_flags[FL_WAIT];
									ev_last_q      <= 1'b0;
									ev_kind_q      <= EV_WAIT;
									fsm_q          <= S_START2;
								end else begin
									fsm_q <= S_DONE;
								end
							end
							CMD_FORCE: begin
								ev_stb_q <= 1'b0;
								visit_q  <= tgt_i;
								fsm_q    <= S_FVISIT;
							end
							default: begin
								if (rd_state != ST_EXECUTING) begin
									ev_kind_q <= EV_REJECT;
								end else begin
									ev_stb_q       <= 1'b0;
									state_q[tgt_i] <= ST_COMPLETE;
									scan_q         <= blocks_q[tgt_i];
									rel_b_q        <= '0;
									fsm_q          <= S_REL;
								end
							end
						endcase
					end
				end
				S_DEP2: begin
					if (rd_state < ST_COMPLETE) begin
						waits_q[tgt_i][bef_i]  <= 1'b1;
						blocks_q[bef_i][tgt_i] <= 1'b1;
					end
					fsm_q <= S_DONE;
				end
				S_START2: begin
					if (rd_wmap == '0) begin
						state_q[tgt_i] <= ST_EXECUTING;
						ev_stb_q       <= rd_flags[FL_EXEC];
						ev_last_q      <= 1'b0;
						ev_kind_q      <= EV_EXEC;
						ev_task_q      <= tgt_q;
					end
					fsm_q <= S_DONE;
				end
				S_FVISIT: begin
					if (rd_state >= ST_FORCED) begin
						fsm_q <= (sp_q == '0) ? S_DONE : S_FSCAN;
					end else begin
						if (rd_state == ST_READY) begin
							state_q[visit_q] <= ST_WAITING;
							ev_stb_q         <= rd_flags[FL_WAIT];
							ev_last_q        <= 1'b0;
							ev_kind_q        <= EV_WAIT;
							ev_task_q        <= 4'(visit_q);
						end
						fsm_q <= S_FVISIT2;
					end
				end
				S_FVISIT2: begin
					if (rd_wmap == '0) begin
						state_q[visit_q] <= ST_EXECUTING;
						ev_stb_q         <= rd_flags[FL_EXEC];
						ev_last_q        <= 1'b0;
						ev_kind_q        <= EV_EXEC;
						ev_task_q        <= 4'(visit_q);
						fsm_q            <= (sp_q == '0) ? S_DONE : S_FSCAN;
					end else begin
						state_q[visit_q]          <= ST_FORCED;
						stk_id_q[sp_q[ID_W-1:0]] <= visit_q;
						stk_b_q[sp_q[ID_W-1:0]]  <= '0;
						sp_q                      <= sp_q + CNT_W'(1);
						fsm_q                     <= S_FSCAN;
					end
				end
				S_FSCAN: begin
					if (top_b == CNT_W'(NUM_TASKS)) begin
						// frame exhausted: return to parent
						sp_q  <= sp_q - CNT_W'(1);
						fsm_q <= (sp_q == CNT_W'(1)) ? S_DONE : S_FSCAN;
					end else begin
						stk_b_q[top] <= top_b + CNT_W'(1);
						if (rd_wmap[top_b[ID_W-1:0]]) begin
							visit_q <= top_b[ID_W-1:0];
							fsm_q   <= S_FVISIT;
						end
					end
				end
				S_REL: begin
					if (scan_q[rel_b_q] && rd_wmap[tgt_i]) begin
						waits_q[rel_b_q] <= rel_new;
						if (rel_new == '0 &&
							(rd_state == ST_WAITING || rd_state == ST_FORCED)) begin
							state_q[rel_b_q] <= ST_EXECUTING;
							ev_stb_q         <= rd_flags[FL_EXEC];
							ev_last_q        <= 1'b0;
							ev_kind_q        <= EV_EXEC;
							ev_task_q        <= 4'(rel_b_q);
						end
					end
					rel_b_q <= rel_b_q + ID_W'(1);
					if (rel_b_q == ID_W'(NUM_TASKS - 1)) begin
						fsm_q <= S_DISP;
					end
				end
				S_DISP: begin
					ev_stb_q       <= rd_flags[FL_DISP];
					ev_last_q      <= 1'b0;
					ev_kind_q      <= EV_DISP;
					ev_task_q      <= tgt_q;
					state_q[tgt_i] <= ST_FREE;
					free_q[tgt_i]  <= 1'b1;
					fsm_q          <= S_DONE;
				end
				default: begin
					ev_stb_q  <= 1'b1;
					ev_last_q <= 1'b1;
					ev_kind_q <= EV_DONE;
					ev_task_q <= tgt_q;
					fsm_q     <= S_IDLE;
				end
			endcase
		end
	end

	assign busy         = (fsm_q != S_IDLE);
	assign event_strobe = ev_stb_q;
	assign event_kind   = ev_kind_q;
	assign event_task   = ev_task_q;
	assign last         = ev_last_q;

endmodule

// ===== tb/task_dependency_scoreboard_checker.sv =====
`timescale 1ns / 1ps

// Watches the command and event channels, predicts every event word and
// compares in order. Keeps its own copy of the task table.
module task_dependency_scoreboard_checker (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic       busy,
	input  logic [2:0] command,
	input  logic [3:0] target_id,
	input  logic [3:0] before_id,
	input  logic       has_waiting_step,
	input  logic       has_execute_step,
	input  logic       has_dispose_step,
	input  logic       event_strobe,
	input  logic [2:0] event_kind,
	input  logic [3:0] event_task,
	input  logic       last,
	output int         fail_count,
	output int         pending_words
);
	import tds_pkg::*;

	typedef struct packed {
		logic [2:0] kind;
		logic [3:0] task_id;
		logic       last;
	} event_word_t;

	event_word_t expected_events[$];

	logic [2:0]           slot_state [NUM_TASKS];
	logic [NUM_TASKS-1:0] waits_on   [NUM_TASKS];
	logic [NUM_TASKS-1:0] blocks     [NUM_TASKS];
	logic [2:0]           steps      [NUM_TASKS];
	logic [NUM_TASKS-1:0] free_ids;
	int                   mismatches;

	function automatic int pop_count(logic [NUM_TASKS-1:0] v);
		int n;
		n = 0;
		for (int i = 0; i < NUM_TASKS; i++) n += v[i];
		return n;
	endfunction

	function automatic void push_event(logic [2:0] k, int id, logic l);
		event_word_t w;
		w.kind    = k;
		w.task_id = id[3:0];
		w.last    = l;
		expected_events.push_back(w);
	endfunction

	function automatic void begin_execute(int id);
		slot_state[id] = ST_EXECUTING;
		if (steps[id][FL_EXEC]) push_event(EV_EXEC, id, 1'b0);
	endfunction

	// depth-first walk over unfinished predecessors, ascending id order
	function automatic void force_walk(int id, int depth);
		logic [NUM_TASKS-1:0] m;
		if (depth > NUM_TASKS) return;
		if (slot_state[id] >= ST_FORCED) return;
		if (slot_state[id] == ST_READY) begin
			slot_state[id] = ST_WAITING;
			if (steps[id][FL_WAIT]) push_event(EV_WAIT, id, 1'b0);
		end
		if (pop_count(waits_on[id]) == 0) begin
			begin_execute(id);
			return;
		end
		slot_state[id] = ST_FORCED;
		m = waits_on[id];
		for (int b = 0; b < NUM_TASKS; b++)
			if (m[b]) force_walk(b, depth + 1);
	endfunction

	function automatic void predict_command(logic [2:0] cmd, int tgt, int bef,
		logic [2:0] flags);
		int id;
		logic [NUM_TASKS-1:0] m;
		if (cmd == CMD_ATTACH) begin
			if (free_ids == '0) begin
				push_event(EV_FULL, 0, 1'b1);
				return;
			end
			id = 0;
			while (!free_ids[id]) id++;
			free_ids[id]   = 1'b0;
			slot_state[id] = ST_READY;
			waits_on[id]   = '0;
			blocks[id]     = '0;
			steps[id]      = flags;
			push_event(EV_DONE, id, 1'b1);
			return;
		end
		if (cmd > CMD_COMPLETE) begin
			push_event(EV_REJECT, tgt, 1'b1);
			return;
		end
		case (cmd)
			CMD_DEPEND: begin
				if (bef == tgt || slot_state[tgt] != ST_READY) begin
					push_event(EV_REJECT, tgt, 1'b1);
					return;
				end
				// finished or free earlier task: nothing recorded
				if (slot_state[bef] < ST_COMPLETE) begin
					waits_on[tgt][bef] = 1'b1;
					blocks[bef][tgt]   = 1'b1;
				end
			end
			CMD_START: begin
				if (slot_state[tgt] == ST_READY) begin
					slot_state[tgt] = ST_WAITING;
					if (steps[tgt][FL_WAIT]) push_event(EV_WAIT, tgt, 1'b0);
					if (pop_count(waits_on[tgt]) == 0) begin_execute(tgt);
				end
			end
			CMD_FORCE: force_walk(tgt, 0);
			default: begin
				if (slot_state[tgt] != ST_EXECUTING) begin
					push_event(EV_REJECT, tgt, 1'b1);
					return;
				end
				slot_state[tgt] = ST_COMPLETE;
				m = blocks[tgt];
				for (int b = 0; b < NUM_TASKS; b++) begin
					if (m[b] && waits_on[b][tgt]) begin
						waits_on[b][tgt] = 1'b0;
						if (pop_count(waits_on[b]) == 0 &&
						    (slot_state[b] == ST_WAITING || slot_state[b] == ST_FORCED))
							begin_execute(b);
					end
				end
				if (steps[tgt][FL_DISP]) push_event(EV_DISP, tgt, 1'b0);
				slot_state[tgt] = ST_FREE;
				free_ids[tgt]   = 1'b1;
			end
		endcase
		push_event(EV_DONE, tgt, 1'b1);
	endfunction

	assign fail_count    = mismatches;
	assign pending_words = expected_events.size();

	always @(posedge clk or negedge arst_n) begin
		event_word_t exp_w;
		if (!arst_n) begin
			expected_events.delete();
			free_ids   = '1;
			mismatches <= 0;
			for (int i = 0; i < NUM_TASKS; i++) slot_state[i] = ST_FREE;
		end else begin
			// check first: a result never lands in the cycle of its own command
			if (event_strobe) begin
				if (expected_events.size() == 0) begin
					if (mismatches < 10)
						$display("unexpected event word kind=%0d task=%0d last=%0b",
							event_kind, event_task, last);
					mismatches <= mismatches + 1;
				end else begin
					exp_w = expected_events.pop_front();
					if (exp_w.kind !== event_kind || exp_w.task_id !== event_task ||
					    exp_w.last !== last) begin
						if (mismatches < 10)
							$display("%s %0d %0d %0b, got kind/task/last %0d %0d %0b",
								"event mismatch: exp kind/task/last",
								exp_w.kind, exp_w.task_id, exp_w.last,
								event_kind, event_task, last);
						mismatches <= mismatches + 1;
					end
				end
			end
			if (start && !busy)
				predict_command(command, target_id, before_id,
					{has_dispose_step, has_execute_step, has_waiting_step});
		end
	end

endmodule

// ===== tb/task_dependency_scoreboard_tb.sv =====
`timescale 1ns / 1ps

// Top: drives command words in bursts and gives the verdict. All prediction
// lives in the checker instance.
module task_dependency_scoreboard_tb;
	import tds_pkg::*;

	localparam int IDLE_LIMIT = 20000; // cycles with no word accepted

	logic       clk;
	logic       arst_n;
	logic       start;
	logic       busy;
	logic [2:0] command;
	logic [3:0] target_id;
	logic [3:0] before_id;
	logic       has_waiting_step;
	logic       has_execute_step;
	logic       has_dispose_step;
	logic       event_strobe;
	logic [2:0] event_kind;
	logic [3:0] event_task;
	logic       last;
	int         fail_count;
	int         pending_words;
	int         idle_cycles;
	int         live_ids[$]; // ids the stimulus believes are attached

	task_dependency_scoreboard u_top (.*);

	task_dependency_scoreboard_checker u_checker (.*);

	always begin
		clk = 1'b1; #5;
		clk = 1'b0; #5;
	end

	// watchdog: any accepted command or event word resets it
	always @(posedge clk) begin
		if ((start && !busy) || event_strobe) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// Present one command word and hold it until the block takes it. start
	// stays high afterwards; the block turns busy on taking it, and the next
	// word or a gap replaces it at the following falling edge.
	task automatic send_word(logic [2:0] cmd, logic [3:0] tgt, logic [3:0] bef,
		logic [2:0] flags);
		command          <= cmd;
		target_id        <= tgt;
		before_id        <= bef;
		has_waiting_step <= flags[0];
		has_execute_step <= flags[1];
		has_dispose_step <= flags[2];
		start            <= 1'b1;
		do @(posedge clk); while (busy);
		@(negedge clk);
	endtask

	// Random gap between bursts; many bursts have no gap at all.
	task automatic maybe_gap();
		if ($urandom_range(0, 2) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 12)) @(negedge clk);
		end
	endtask

	function automatic logic [3:0] pick_live();
		if (live_ids.size() == 0) return 4'($urandom_range(0, 15));
		return 4'(live_ids[$urandom_range(0, live_ids.size() - 1)]);
	endfunction

	// Attach, with bookkeeping of which id the block should hand out.
	task automatic attach_one(logic [2:0] flags);
		int id;
		send_word(CMD_ATTACH, 4'($urandom), 4'($urandom), flags);
		if (live_ids.size() < NUM_TASKS) begin
			id = 0;
			while (id inside {live_ids}) id++;
			live_ids.push_back(id);
		end
	endtask

	initial begin
		int burst;
		int sent;
		int k;
		logic [3:0] a;
		logic [3:0] b;
		arst_n           = 1'b0;
		start            = 1'b0;
		command          = CMD_ATTACH;
		target_id        = '0;
		before_id        = '0;
		has_waiting_step = 1'b0;
		has_execute_step = 1'b0;
		has_dispose_step = 1'b0;
		idle_cycles      = 0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: fill the table, then one more attach sees it full.
		for (int i = 0; i < NUM_TASKS; i++) attach_one(3'(i % 8));
		attach_one(3'b111);
		// unknown codes and reject paths
		send_word(3'd5, 4'd3, 4'd0, 3'b000);
		send_word(3'd7, 4'd15, 4'd15, 3'b111);
		send_word(CMD_DEPEND, 4'd4, 4'd4, 3'b000);       // self dependency
		send_word(CMD_COMPLETE, 4'd0, 4'd0, 3'b000);     // not executing
		// a chain 3 <- 2 <- 1, plus 3 <- 5; repeated dependency recorded once
		send_word(CMD_DEPEND, 4'd3, 4'd2, 3'b000);
		send_word(CMD_DEPEND, 4'd3, 4'd2, 3'b000);
		send_word(CMD_DEPEND, 4'd2, 4'd1, 3'b000);
		send_word(CMD_DEPEND, 4'd3, 4'd5, 3'b000);
		send_word(CMD_FORCE, 4'd3, 4'd0, 3'b000);        // depth-first walk
		send_word(CMD_FORCE, 4'd3, 4'd0, 3'b000);        // already forced
		send_word(CMD_START, 4'd1, 4'd0, 3'b000);        // not ready
		send_word(CMD_DEPEND, 4'd3, 4'd6, 3'b000);       // target not ready
		send_word(CMD_COMPLETE, 4'd1, 4'd0, 3'b000);     // releases 2
		send_word(CMD_COMPLETE, 4'd5, 4'd0, 3'b000);
		send_word(CMD_DEPEND, 4'd7, 4'd1, 3'b000);       // earlier one freed
		send_word(CMD_START, 4'd15, 4'd0, 3'b000);
		send_word(CMD_COMPLETE, 4'd15, 4'd0, 3'b000);
		live_ids.delete();
		for (int i = 0; i < NUM_TASKS; i++)
			if (!(i inside {1, 5, 15})) live_ids.push_back(i);

		// Random: mostly well-formed sequences on live ids, some noise.
		sent = 0;
		while (sent < 300) begin
			burst = $urandom_range(1, 8);
			for (int j = 0; j < burst; j++) begin
				k = $urandom_range(0, 99);
				a = pick_live();
				b = pick_live();
				if (k < 18) attach_one(3'($urandom));
				else if (k < 45) send_word(CMD_DEPEND, a, b, 3'($urandom));
				else if (k < 60) send_word(CMD_START, a, 4'($urandom), 3'($urandom));
				else if (k < 72) send_word(CMD_FORCE, a, 4'($urandom), 3'($urandom));
				else if (k < 94) begin
					send_word(CMD_COMPLETE, a, 4'($urandom), 3'($urandom));
					// tracking is approximate: the checker holds the truth
					if ($urandom_range(0, 2) == 0)
						live_ids = live_ids.find(x) with (x != a);
				end else
					send_word(3'($urandom_range(0, 7)), 4'($urandom), 4'($urandom),
						3'($urandom));
				sent++;
			end
			maybe_gap();
			// every so often resync the live list from scratch
			if ($urandom_range(0, 15) == 0) begin
				live_ids.delete();
				for (int i = 0; i < NUM_TASKS; i++) live_ids.push_back(i);
			end
		end

		// drain: busy low and no words pending, then a short tail
		start <= 1'b0;
		while (busy || pending_words != 0) @(negedge clk);
		repeat (60) @(negedge clk);
		if (fail_count == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
